[src/plwl_pkg.sv]
package plwl_pkg;

  // Fixed field widths and arithmetic constants
  localparam int NUM_BANDS = 4;
  localparam int X_FRAC_BITS = 10;
  localparam int X_W = 26;
  localparam int Y_W = 32;
  localparam int PX_W = 16;
  localparam int IDX_W = 10;
  localparam int YS_W = NUM_BANDS * Y_W;
  localparam int PT_W = PX_W + YS_W;
  localparam int IN_DATA_W = 168;
  localparam int OUT_DATA_W = 160;

  // Input tdata layout
  localparam int IN_X_LO = 0;
  localparam int IN_Y_LO = 26;
  localparam int IN_IDX_LO = 154;

  // Output tdata layout
  localparam int OUT_ST_LO = 0;
  localparam int OUT_SZ_LO = 2;
  localparam int OUT_BASE_LO = 13;
  localparam int OUT_EV_BIT = 29;
  localparam int OUT_VAL_LO = 30;

  // Op, kind and status codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_INT = 2'd1;
  localparam logic [1:0] ST_TOO_MANY = 2'd2;
  localparam logic [1:0] ST_SPAN = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic cap;
    logic set_err1;
    logic set_err2;
    logic ins_init;
    logic ins_rd;
    logic ins_shift;
    logic ins_place;
    logic bld_fail;
    logic bld_init;
    logic take_prev;
    logic rd_pt;
    logic take_cur;
    logic adv_prev;
    logic div_start;
    logic div_take;
    logic fill_wr;
    logic last_wr;
    logic out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last;
    logic frac_bad;
    logic full;
    logic j_zero;
    logic shift;
    logic bld_fail;
    logic pts_done;
    logic dx_zero;
    logic div_done;
    logic band_last;
    logic k_last;
    logic out_free;
  } stat_t;

endpackage

[src/plwl_ram.sv]
module plwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/plwl_div.sv]
module plwl_div #(
  parameter int NW = 33,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [NW-1:0]    q_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    dv_r;
  logic             done_r;
  logic [DW:0]      part;
  logic             ge;

  // One quotient bit per cycle, restoring
  assign part = {rem_r, q_r[NW-1]};
  assign ge   = part >= {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend;
        rem_r  <= '0;
        dv_r   <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? DW'(part - {1'b0, dv_r}) : DW'(part);
        q_r   <= {q_r[NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

[src/plwl_dp.sv]
module plwl_dp #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_TABLE  = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  plwl_pkg::cmd_t                     cmd,
  output plwl_pkg::stat_t                    st,
  input  logic [plwl_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  input  logic                               cfg_valid,
  input  logic [2:0]                         cfg_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [plwl_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tuser
);

  localparam int PAW = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int TAW = (MAX_TABLE > 1) ? $clog2(MAX_TABLE) : 1;
  localparam int SW  = $clog2(MAX_TABLE + 1);
  localparam int NB  = plwl_pkg::NUM_BANDS;
  localparam int YW  = plwl_pkg::Y_W;
  localparam int FB  = plwl_pkg::X_FRAC_BITS;

  // Captured request
  logic                          op_r, last_r;
  logic [plwl_pkg::X_W-1:0]      x_r;
  logic [plwl_pkg::YS_W-1:0]     y_r;
  logic [plwl_pkg::IDX_W-1:0]    idx_r;

  // Point store bookkeeping
  logic [CW-1:0]                 count_r, j_r, pi_r;
  logic [1:0]                    err_r;
  logic signed [15:0]            lo_r, hi_r;
  logic [2:0]                    bands_r, nb_r;

  // Table state
  logic [SW-1:0]                 built_r;
  logic [15:0]                   base_r;
  logic [1:0]                    status_r;
  logic [TAW-1:0]                waddr_r;

  // Segment state
  logic [plwl_pkg::PT_W-1:0]     prev_r, cur_r;
  logic [16:0]                   dx_r, k_r;
  logic [1:0]                    band_r;
  logic [31:0]                   a_r [NB];
  logic [17:0]                   b_r [NB];
  logic [31:0]                   q_r [NB];
  logic [17:0]                   r_r [NB];
  logic                          neg_r [NB];

  // Output register
  logic                          ov_r, okind_r;
  logic [plwl_pkg::OUT_DATA_W-1:0] od_r;

  // Memories
  logic                          pt_we;
  logic [PAW-1:0]                pt_waddr, pt_raddr;
  logic [plwl_pkg::PT_W-1:0]     pt_wdata, pt_rdata;
  logic                          tb_we;
  logic [plwl_pkg::YS_W-1:0]     tb_wdata, tb_rdata;

  plwl_ram #(.WIDTH(plwl_pkg::PT_W), .DEPTH(MAX_POINTS)) u_pts (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  plwl_ram #(.WIDTH(plwl_pkg::YS_W), .DEPTH(MAX_TABLE)) u_tbl (
    .clk(clk), .we(tb_we), .waddr(waddr_r), .wdata(tb_wdata),
    .raddr(TAW'(idx_r)), .rdata(tb_rdata)
  );

  // Round x to an integer and check its fraction
  logic [FB-1:0]   frac;
  logic [26:0]     xsum;
  logic [26-FB:0]  xsh;
  logic signed [15:0] xi;

  assign frac = x_r[FB-1:0];
  assign xsum = {1'b0, x_r ^ 26'h2000000} + 27'(1 << (FB - 1));
  assign xsh  = xsum[26:FB];
  assign xi   = (xsh > (27 - FB)'(16'hFFFF)) ? 16'sh7FFF : (16'(xsh) ^ 16'h8000);

  // Build checks
  logic [16:0] span;
  logic [1:0]  bld_status;
  logic        span_bad;

  assign span     = ({hi_r[15], hi_r} - {lo_r[15], lo_r}) + 17'd1;
  assign span_bad = {1'b0, span} > 18'(MAX_TABLE);
  always_comb begin
    if (err_r != plwl_pkg::ST_OK)  bld_status = err_r;
    else if (count_r == '0)        bld_status = plwl_pkg::ST_OK;
    else if (span_bad)             bld_status = plwl_pkg::ST_SPAN;
    else                           bld_status = plwl_pkg::ST_OK;
  end

  // Band difference for the divider
  logic signed [15:0] prev_x, cur_x, rd_x;
  logic [31:0]        y1_sel, y2_sel;
  logic [32:0]        dsel, dmag;
  logic [32:0]        quot;
  logic [16:0]        rem;
  logic               div_done;

  assign prev_x = prev_r[15:0];
  assign cur_x  = cur_r[15:0];
  assign rd_x   = pt_rdata[15:0];
  assign y1_sel = prev_r[16 + band_r * YW +: YW];
  assign y2_sel = cur_r[16 + band_r * YW +: YW];
  assign dsel   = {y2_sel[31], y2_sel} - {y1_sel[31], y1_sel};
  assign dmag   = dsel[32] ? -dsel : dsel;

  plwl_div #(.NW(33), .DW(17)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(dmag),
    .divisor(dx_r), .done(div_done), .quot(quot), .rem(rem)
  );

  // Entry values for the fill and the final point
  logic [plwl_pkg::YS_W-1:0] fill_val, last_val;
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      logic [31:0] y1;
      y1 = prev_r[16 + b * YW +: YW];
      fill_val[b * YW +: YW] = (3'(b) < nb_r) ? (neg_r[b] ? y1 - q_r[b] : y1 + q_r[b]) : '0;
      last_val[b * YW +: YW] = (3'(b) < nb_r) ? y1 : '0;
    end
  end

  // Memory port control
  always_comb begin
    pt_we    = cmd.ins_shift || cmd.ins_place;
    pt_waddr = PAW'(j_r);
    pt_wdata = cmd.ins_shift ? pt_rdata : {y_r, xi};
    if (cmd.ins_rd)      pt_raddr = PAW'(j_r - 1'b1);
    else if (cmd.rd_pt)  pt_raddr = PAW'(pi_r);
    else                 pt_raddr = '0;
    tb_we    = cmd.fill_wr || cmd.last_wr;
    tb_wdata = cmd.last_wr ? last_val : fill_val;
  end

  // Status toward the controller
  assign st.last      = last_r;
  assign st.frac_bad  = !((frac <= FB'(1)) || (frac == {FB{1'b1}}));
  assign st.full      = count_r >= CW'(MAX_POINTS);
  assign st.j_zero    = j_r == '0;
  assign st.shift     = rd_x > xi;
  assign st.bld_fail  = (err_r != plwl_pkg::ST_OK) || (count_r == '0) || span_bad;
  assign st.pts_done  = pi_r == count_r;
  assign st.dx_zero   = rd_x == prev_x;
  assign st.div_done  = div_done;
  assign st.band_last = band_r == 2'(NB - 1);
  assign st.k_last    = k_r == dx_r - 17'd1;
  assign st.out_free  = !ov_r || out_tready;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      err_r    <= plwl_pkg::ST_OK;
      built_r  <= '0;
      base_r   <= '0;
      bands_r  <= 3'd1;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_valid) bands_r <= cfg_data;
      if (cmd.set_err1 && err_r == plwl_pkg::ST_OK) err_r <= plwl_pkg::ST_NOT_INT;
      if (cmd.set_err2 && err_r == plwl_pkg::ST_OK) err_r <= plwl_pkg::ST_TOO_MANY;
      if (cmd.ins_place) count_r <= count_r + 1'b1;
      if (cmd.bld_fail) begin
        built_r <= '0;
        base_r  <= '0;
      end
      if (cmd.last_wr) begin
        built_r <= SW'(span);
        base_r  <= lo_r;
      end
      if (cmd.bld_fail || cmd.last_wr) begin
        count_r <= '0;
        err_r   <= plwl_pkg::ST_OK;
      end
      if (cmd.out_load)     ov_r <= 1'b1;
      else if (out_tready)  ov_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r   <= in_tuser;
      last_r <= in_tlast;
      x_r    <= in_tdata[plwl_pkg::IN_X_LO +: plwl_pkg::X_W];
      y_r    <= in_tdata[plwl_pkg::IN_Y_LO +: plwl_pkg::YS_W];
      idx_r  <= in_tdata[plwl_pkg::IN_IDX_LO +: plwl_pkg::IDX_W];
    end
    if (cmd.ins_init)  j_r <= count_r;
    if (cmd.ins_shift) j_r <= j_r - 1'b1;
    if (cmd.ins_place) begin
      if (count_r == '0) begin
        lo_r <= xi;
        hi_r <= xi;
      end else begin
        if (xi < lo_r) lo_r <= xi;
        if (xi > hi_r) hi_r <= xi;
      end
    end
    if (cmd.bld_fail) status_r <= bld_status;
    if (cmd.last_wr)  status_r <= plwl_pkg::ST_OK;
    if (cmd.bld_init) begin
      // clamp the band count to one through four
      if (bands_r == 3'd0)                nb_r <= 3'd1;
      else if (bands_r > 3'(NB))          nb_r <= 3'(NB);
      else                                nb_r <= bands_r;
      waddr_r <= '0;
      pi_r    <= CW'(1);
    end
    if (cmd.take_prev) prev_r <= pt_rdata;
    if (cmd.take_cur) begin
      cur_r  <= pt_rdata;
      dx_r   <= {rd_x[15], rd_x} - {prev_x[15], prev_x};
      pi_r   <= pi_r + 1'b1;
      band_r <= '0;
      k_r    <= '0;
    end
    if (cmd.div_take) begin
      a_r[band_r]   <= quot[31:0];
      b_r[band_r]   <= {rem, 1'b0};
      q_r[band_r]   <= '0;
      r_r[band_r]   <= {1'b0, dx_r};
      neg_r[band_r] <= dsel[32];
      band_r        <= band_r + 1'b1;
    end
    // step every band one entry along the segment
    if (cmd.fill_wr) begin
      for (int b = 0; b < NB; b++) begin
        logic [18:0] rs;
        rs = {1'b0, r_r[b]} + {1'b0, b_r[b]};
        if (rs >= {1'b0, dx_r, 1'b0}) begin
          r_r[b] <= 18'(rs - {1'b0, dx_r, 1'b0});
          q_r[b] <= q_r[b] + a_r[b] + 32'd1;
        end else begin
          r_r[b] <= 18'(rs);
          q_r[b] <= q_r[b] + a_r[b];
        end
      end
      waddr_r <= waddr_r + 1'b1;
      k_r     <= k_r + 17'd1;
    end
    if (cmd.adv_prev) prev_r <= cur_r;
    if (cmd.out_load) begin
      logic ev;
      ev = (op_r == plwl_pkg::OP_READ) && ({{(17 - plwl_pkg::IDX_W){1'b0}}, idx_r} < 17'(built_r));
      okind_r <= op_r;
      od_r    <= '0;
      od_r[plwl_pkg::OUT_ST_LO +: 2]    <= (op_r == plwl_pkg::OP_READ) ? plwl_pkg::ST_OK : status_r;
      od_r[plwl_pkg::OUT_SZ_LO +: 11]   <= 11'(built_r);
      od_r[plwl_pkg::OUT_BASE_LO +: 16] <= base_r;
      od_r[plwl_pkg::OUT_EV_BIT]        <= ev;
      od_r[plwl_pkg::OUT_VAL_LO +: plwl_pkg::YS_W] <= ev ? tb_rdata : '0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = okind_r;

endmodule

[src/plwl_ctrl.sv]
module plwl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tuser,
  output logic             in_tready,
  input  plwl_pkg::stat_t  st,
  output plwl_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_LD_CHK, S_INS_RD, S_INS_CMP, S_BLD, S_BLD_P0, S_BLD_NEXT,
    S_BLD_CUR, S_DIV_GO, S_DIV_WAIT, S_FILL, S_BLD_LAST, S_RD_TBL, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = state_r == S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = (in_tuser == plwl_pkg::OP_READ) ? S_RD_TBL : S_LD_CHK;
        end
      end
      S_LD_CHK: begin
        if (st.frac_bad) begin
          cmd.set_err1 = 1'b1;
          state_nxt    = st.last ? S_BLD : S_IDLE;
        end else if (st.full) begin
          cmd.set_err2 = 1'b1;
          state_nxt    = st.last ? S_BLD : S_IDLE;
        end else begin
          cmd.ins_init = 1'b1;
          state_nxt    = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (st.j_zero) begin
          cmd.ins_place = 1'b1;
          state_nxt     = st.last ? S_BLD : S_IDLE;
        end else begin
          cmd.ins_rd = 1'b1;
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (st.shift) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = S_INS_RD;
        end else begin
          cmd.ins_place = 1'b1;
          state_nxt     = st.last ? S_BLD : S_IDLE;
        end
      end
      S_BLD: begin
        if (st.bld_fail) begin
          cmd.bld_fail = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.bld_init = 1'b1;
          state_nxt    = S_BLD_P0;
        end
      end
      S_BLD_P0: begin
        cmd.take_prev = 1'b1;
        state_nxt     = S_BLD_NEXT;
      end
      S_BLD_NEXT: begin
        if (st.pts_done) begin
          state_nxt = S_BLD_LAST;
        end else begin
          cmd.rd_pt = 1'b1;
          state_nxt = S_BLD_CUR;
        end
      end
      S_BLD_CUR: begin
        if (st.dx_zero) begin
          cmd.take_prev = 1'b1;
          cmd.take_cur  = 1'b1;
          state_nxt     = S_BLD_NEXT;
        end else begin
          cmd.take_cur = 1'b1;
          state_nxt    = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (st.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = st.band_last ? S_FILL : S_DIV_GO;
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (st.k_last) begin
          cmd.adv_prev = 1'b1;
          state_nxt    = S_BLD_NEXT;
        end
      end
      S_BLD_LAST: begin
        cmd.last_wr = 1'b1;
        state_nxt   = S_OUT;
      end
      S_RD_TBL: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/piecewise_linear_lut_builder_core.sv]
// Load without build: the request is captured and checked, each stored point with a larger x
// is shifted up one place, then the new point is placed; a dropped point is not stored.
// Build: per point pair with distinct x, 4 divider passes on the shared bit-serial divider,
// then one table entry per cycle through the single table write port.
// Table read: capture, table read, then a registered result; one request in flight at a time.
// Synchronous active-low reset empties the point store, clears table size and base,
// sets the band count to one; the memories are not cleared.
module piecewise_linear_lut_builder_core #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_TABLE  = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // x_fixed, y_band0, y_band1, y_band2, y_band3, read_index, zero fill
  input  logic [167:0] in_tdata,
  // op
  input  logic         in_tuser,
  // last_point
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, table_size, base_x, entry_valid, value_band0..value_band3, zero fill
  output logic [159:0] out_tdata,
  // kind
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_data
);

  plwl_pkg::cmd_t  cmd;
  plwl_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  plwl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tuser(in_tuser),
    .in_tready(in_tready), .st(st), .cmd(cmd)
  );

  plwl_dp #(.MAX_POINTS(MAX_POINTS), .MAX_TABLE(MAX_TABLE)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast), .cfg_valid(cfg_valid),
    .cfg_data(cfg_data), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

[src/plwl_chk.sv]
module plwl_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata,
  input logic         out_tuser
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Status results carry no entry
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> !out_tdata[29] && out_tdata[159:30] == '0)
    else $error("status result carries entry data");

  // Entry results carry ok status
  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[1:0] == 2'd0)
    else $error("entry result has nonzero status");

  // A valid entry needs a built table
  a_entry_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tdata[29] |-> out_tdata[12:2] != 11'd0)
    else $error("valid entry with empty table");

endmodule

bind piecewise_linear_lut_builder_core plwl_chk u_chk (.*);

[verif/tb_top.sv]
module tb_top;

  localparam int MAXP = 64;
  localparam int MAXT = 1024;
  localparam int LIMIT = 6000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [167:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [159:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_data = '0;

  always #2 clk = ~clk;

  piecewise_linear_lut_builder_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic op;
    logic signed [25:0] x;
    logic [3:0][31:0] y;
    logic last;
    logic [9:0] idx;
  } req_t;

  typedef struct packed {
    logic kind;
    logic [1:0] status;
    logic [10:0] size;
    logic [15:0] base;
    logic ev;
    logic [3:0][31:0] val;
  } res_t;

  // predictor state
  int pt_x[MAXP];
  logic signed [31:0] pt_y[MAXP][4];
  int pt_cnt;
  int ld_err;
  logic signed [31:0] lut[MAXT][4];
  int tbl_len;
  int lut_base;
  int band_cfg;

  res_t exp_q[$];
  int errors;
  int mism;
  int cycles;
  bit idle_free;
  bit hold_out;

  function automatic logic signed [31:0] lerp(longint y1, longint y2, longint k, longint dx);
    longint num, mag, q;
    num = k * (y2 - y1);
    mag = (num < 0) ? -num : num;
    q = (2 * mag + dx) / (2 * dx);
    return 32'(y1 + ((num < 0) ? -q : q));
  endfunction

  task automatic store_point(req_t r);
    int fr, xi, pos;
    fr = int'(r.x[9:0]);
    if (!(fr <= 1 || fr >= 1023)) begin
      if (ld_err == 0) ld_err = plwl_pkg::ST_NOT_INT;
      return;
    end
    if (pt_cnt >= MAXP) begin
      if (ld_err == 0) ld_err = plwl_pkg::ST_TOO_MANY;
      return;
    end
    xi = int'((longint'(r.x) + 512) >>> 10);
    if (xi > 32767) xi = 32767;
    pos = pt_cnt;
    while (pos > 0 && pt_x[pos-1] > xi) pos--;
    for (int i = pt_cnt; i > pos; i--) begin
      pt_x[i] = pt_x[i-1];
      pt_y[i] = pt_y[i-1];
    end
    pt_x[pos] = xi;
    for (int b = 0; b < 4; b++) pt_y[pos][b] = r.y[b];
    pt_cnt++;
  endtask

  function automatic int build_lut();
    int st, nb, span, dx, off;
    st = ld_err;
    nb = band_cfg < 1 ? 1 : (band_cfg > 4 ? 4 : band_cfg);
    span = 0;
    if (st == 0 && pt_cnt > 0) begin
      span = pt_x[pt_cnt-1] - pt_x[0] + 1;
      if (span > MAXT) st = plwl_pkg::ST_SPAN;
    end
    if (st != 0 || pt_cnt == 0) begin
      tbl_len = 0;
      lut_base = 0;
    end else begin
      for (int b = 0; b < 4; b++) begin
        if (b >= nb) begin
          for (int k = 0; k < span; k++) lut[k][b] = 0;
        end else begin
          for (int i = 0; i + 1 < pt_cnt; i++) begin
            dx = pt_x[i+1] - pt_x[i];
            off = pt_x[i] - pt_x[0];
            for (int k = 0; k < dx; k++)
              lut[off+k][b] = lerp(pt_y[i][b], pt_y[i+1][b], k, dx);
          end
          lut[span-1][b] = pt_y[pt_cnt-1][b];
        end
      end
      tbl_len = span;
      lut_base = pt_x[0];
    end
    pt_cnt = 0;
    ld_err = 0;
    return st;
  endfunction

  // Advance the predictor by one request; push any expected result.
  task automatic predict(req_t r);
    res_t e;
    e = '0;
    if (r.op == plwl_pkg::OP_LOAD) begin
      store_point(r);
      if (!r.last) return;
      e.kind = plwl_pkg::KIND_STATUS;
      e.status = 2'(build_lut());
    end else begin
      e.kind = plwl_pkg::KIND_ENTRY;
      e.ev = int'(r.idx) < tbl_len;
      if (e.ev) for (int b = 0; b < 4; b++) e.val[b] = lut[r.idx][b];
    end
    e.size = 11'(tbl_len);
    e.base = 16'(lut_base);
    exp_q.push_back(e);
  endtask

  task automatic send(req_t r);
    in_tuser <= r.op;
    in_tlast <= r.last;
    in_tdata <= {4'b0, r.idx, r.y, r.x};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict(r);
    // drop valid at random, but not during the quiet stretch
    if (!idle_free && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 12);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task automatic write_bands(int v);
    cfg_data <= 3'(v);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    band_cfg = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic req_t mk_load(int xint, int frac, bit last);
    req_t r;
    r = '0;
    r.op = plwl_pkg::OP_LOAD;
    r.x = 26'((longint'(xint) << 10) + frac);
    for (int b = 0; b < 4; b++) r.y[b] = $urandom;
    r.last = last;
    r.idx = 10'($urandom);
    return r;
  endfunction

  function automatic req_t mk_read(int idx);
    req_t r;
    r = '0;
    r.op = plwl_pkg::OP_READ;
    r.x = 26'($urandom);
    r.y = {$urandom, $urandom, $urandom, $urandom};
    r.last = $urandom_range(1);
    r.idx = 10'(idx);
    return r;
  endfunction

  // Check each returned result against the oldest expectation.
  always @(posedge clk) begin
    res_t got, e;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[1:0], out_tdata[12:2], out_tdata[28:13], out_tdata[29],
             out_tdata[157:30]};
      if (exp_q.size() == 0) begin
        errors++;
        if (mism < 10) $display("unexpected result %h", got);
        mism++;
      end else begin
        e = exp_q.pop_front();
        if (got !== e) begin
          errors++;
          if (mism < 10) $display("mismatch exp %h got %h", e, got);
          mism++;
        end
      end
    end
  end

  // Drive the result ready with random stalls, plus one long hold-off.
  always @(posedge clk) begin
    if (hold_out) out_tready <= 1'b0;
    else out_tready <= idle_free || $urandom_range(99) >= 12;
  end

  initial begin
    int holdc;
    hold_out = 0;
    wait (idle_free);
    hold_out = 1;
    for (holdc = 0; holdc < 400; holdc++) @(posedge clk);
    hold_out = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Random table session: a set of points then reads.
  task automatic session(int npts, int spanmax, bit noisy);
    int base, xv, fr, n;
    base = $urandom_range(65535) - 32768;
    if (base > 32767 - spanmax) base = 32767 - spanmax;
    for (int i = 0; i < npts; i++) begin
      xv = base + $urandom_range(spanmax);
      fr = $urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? 1 : 1023);
      if (noisy && $urandom_range(30) == 0) fr = $urandom_range(1021, 2);
      if (fr == 1023) xv = xv + 1;
      send(mk_load(xv - (fr == 1023 ? 1 : 0) - (fr == 1023 ? 0 : 0), fr,
                   i == npts - 1));
    end
    n = $urandom_range(12, 3);
    for (int i = 0; i < n; i++)
      send(mk_read($urandom_range(3) == 0 ? $urandom_range(1023) :
                   (tbl_len > 0 ? $urandom_range(tbl_len - 1) : 0)));
  endtask

  initial begin
    req_t dir[$];
    res_t want[$];
    bit chk[$];
    req_t r;
    int total;
    pt_cnt = 0; ld_err = 0; tbl_len = 0; lut_base = 0; band_cfg = 1;
    errors = 0; mism = 0; cycles = 0; idle_free = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: reads after reset and error builds have known results.
    r = mk_read(0); dir.push_back(r);
    want.push_back({plwl_pkg::KIND_ENTRY, 158'b0}); chk.push_back(1);
    r = mk_read(1023); dir.push_back(r);
    want.push_back({plwl_pkg::KIND_ENTRY, 158'b0}); chk.push_back(1);
    r = mk_load(5, 512, 1); dir.push_back(r);
    want.push_back({plwl_pkg::KIND_STATUS, plwl_pkg::ST_NOT_INT, 156'b0}); chk.push_back(1);
    r = mk_load(0, 0, 0); dir.push_back(r); want.push_back('0); chk.push_back(0);
    r = mk_load(2000, 0, 1); dir.push_back(r);
    want.push_back({plwl_pkg::KIND_STATUS, plwl_pkg::ST_SPAN, 156'b0}); chk.push_back(1);
    r = mk_load(32767, 1023, 1); dir.push_back(r); want.push_back('0); chk.push_back(0);
    r = mk_read(0); dir.push_back(r); want.push_back('0); chk.push_back(0);
    r = mk_load(-32768, 0, 0); dir.push_back(r); want.push_back('0); chk.push_back(0);
    r = mk_load(-32768, 1, 0); dir.push_back(r); want.push_back('0); chk.push_back(0);
    r = mk_load(-32765, 0, 0); dir.push_back(r); want.push_back('0); chk.push_back(0);
    r = mk_load(-32766, 1023, 0); dir.push_back(r); want.push_back('0); chk.push_back(0);
    r = mk_load(-32760, 0, 1); r.y = {32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    dir.push_back(r); want.push_back('0); chk.push_back(0);
    for (int i = 0; i < 10; i++) begin
      r = mk_read(i); dir.push_back(r); want.push_back('0); chk.push_back(0);
    end
    for (int i = 0; i < dir.size(); i++) begin
      send(dir[i]);
      if (chk[i] && exp_q[$] !== want[i]) begin
        errors++;
        $display("directed row %0d predictor disagrees", i);
      end
    end
    drain();

    // Store overflow: one point past capacity.
    write_bands(4);
    for (int i = 0; i <= MAXP; i++) send(mk_load(i, 0, i == MAXP));
    send(mk_read(0));
    total = dir.size() + MAXP + 2;
    drain();

    // Random sessions across band settings, with a quiet stretch.
    while (total < 1550) begin
      if ($urandom_range(9) == 0) begin
        drain();
        write_bands($urandom_range(7));
      end
      idle_free = (total > 600 && total < 800);
      if ($urandom_range(15) == 0) begin
        r = mk_load($urandom_range(65535) - 32768, 0, 0);
        r.x = 26'($urandom);
        r.last = $urandom_range(1);
        send(r);
        total++;
      end else begin
        int np, sm;
        np = $urandom_range(9) == 0 ? $urandom_range(MAXP + 3, 2) : $urandom_range(6, 1);
        sm = $urandom_range(7) == 0 ? 1100 : $urandom_range(40, 0);
        session(np, sm, 1);
        total += np + 7;
      end
    end
    drain();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
src/plwl_pkg.sv
src/plwl_ram.sv
src/plwl_div.sv
src/plwl_dp.sv
src/plwl_ctrl.sv
src/piecewise_linear_lut_builder_core.sv
src/plwl_chk.sv
verif/tb_top.sv
